/* rtl/cbm_pkg.sv */
// Shared types, codes and a helper function for the cartridge bank mapper.
`default_nettype none

package cbm_pkg;

	// Bus access kinds
	localparam logic [1:0] REQ_ROM_RD = 2'd0;
	localparam logic [1:0] REQ_ROM_WR = 2'd1;
	localparam logic [1:0] REQ_RAM_RD = 2'd2;
	localparam logic [1:0] REQ_RAM_WR = 2'd3;

	// Mapper kinds
	localparam logic [1:0] MAPPER_NONE = 2'd0;
	localparam logic [1:0] MAPPER_MBC1 = 2'd1;
	localparam logic [1:0] MAPPER_MBC5 = 2'd2;

	// Result targets
	localparam logic [1:0] TGT_NONE = 2'd0;
	localparam logic [1:0] TGT_ROM  = 2'd1;
	localparam logic [1:0] TGT_RAM  = 2'd2;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAPPER_TYPE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANK_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_PRESENT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RUMBLE_PRESENT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_IS_2KIB    = 3'd5;
	localparam int unsigned CFG_DATA_W = 10;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] bus_addr;
		logic [7:0]  bus_data;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  target;
		logic [22:0] phys_addr;
		logic        write_strobe;
		logic [7:0]  write_byte;
		logic        out_of_range;
	} out_item_t;

	typedef struct packed {
		logic [1:0] mapper_type;
		logic [9:0] rom_bank_count;
		logic [4:0] ram_bank_count;
		logic       ram_present;
		logic       rumble_present;
		logic       ram_is_2kib;
	} cfg_regs_t;

	typedef struct packed {
		logic [8:0] rom_bank;
		logic [3:0] ram_bank;
		logic       banking_mode;
		logic       ram_enabled;
	} bank_state_t;

	// MBC1 ROM bank mask: h | (h - 1) with h = min(count / 2, 16), kept to 5 bits.
	function automatic logic [4:0] mbc1_mask(input logic [9:0] count);
		logic [8:0] half;
		logic [4:0] h;
		half = count[9:1];
		h = (half > 9'd16) ? 5'd16 : half[4:0];
		return h | (h - 5'd1);
	endfunction

endpackage

`default_nettype wire

/* rtl/cbm_bank_regs.sv */
// Bank register file of the mapper, loaded by ROM-area writes.
`default_nettype none

module cbm_bank_regs
	import cbm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        upd,
	input  wire in_item_t    item,
	input  wire cfg_regs_t   cfg,
	output bank_state_t      state
);

	bank_state_t state_q, state_d;
	logic [8:0]  mbc5_mask;
	logic [4:0]  mask1;
	logic [15:0] a;
	logic [7:0]  v;

	assign a = item.bus_addr;
	assign v = item.bus_data;
	assign mbc5_mask = cfg.rom_bank_count[8:0] - 9'd1;
	assign mask1 = mbc1_mask(cfg.rom_bank_count);

	always_comb begin
		state_d = state_q;
		if (upd && item.req_type == REQ_ROM_WR && !a[15]) begin
			case (cfg.mapper_type)
				MAPPER_MBC1: begin
					if (a <= 16'h1FFF) begin
						state_d.ram_enabled = (v[3:0] == 4'hA) && cfg.ram_present;
					end else if (a <= 16'h3FFF) begin
						if (v[4:0] == 5'd0)
							state_d.rom_bank = 9'd1;
						else
							state_d.rom_bank = {4'd0, v[4:0] & mask1};
					end else if (a <= 16'h5FFF) begin
						state_d.ram_bank = {2'd0, v[1:0]};
					end else begin
						state_d.banking_mode = v[0];
					end
				end
				MAPPER_MBC5: begin
					if (a <= 16'h1FFF) begin
						state_d.ram_enabled = (v[3:0] == 4'hA) && cfg.ram_present
							&& (cfg.ram_bank_count != 5'd0);
					end else if (a <= 16'h2FFF) begin
						state_d.rom_bank = {state_q.rom_bank[8], v} & mbc5_mask;
					end else if (a <= 16'h3FFF) begin
						state_d.rom_bank = {v[0], state_q.rom_bank[7:0]} & mbc5_mask;
					end else if (a <= 16'h5FFF) begin
						state_d.ram_bank = v[3:0] & (cfg.rumble_present ? 4'h7 : 4'hF);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.rom_bank     <= 9'd1;
			state_q.ram_bank     <= 4'd0;
			state_q.banking_mode <= 1'b0;
			state_q.ram_enabled  <= 1'b0;
		end else begin
			state_q <= state_d;
		end
	end

	assign state = state_q;

endmodule

`default_nettype wire

/* rtl/cbm_xlate.sv */
// Address translation from one bus access to a ROM or RAM byte address.
`default_nettype none

module cbm_xlate
	import cbm_pkg::*;
#(
	parameter int unsigned ROM_ADDR_BITS = 23,
	parameter int unsigned RAM_ADDR_BITS = 17
) (
	input  wire in_item_t    item,
	input  wire cfg_regs_t   cfg,
	input  wire bank_state_t state,
	output out_item_t        result
);

	logic [15:0] a;
	logic [12:0] off;
	logic [1:0]  hi;
	logic [4:0]  mask1;
	logic [6:0]  zb;
	logic [6:0]  bank1;
	logic [23:0] rom_phys, rom_size, rom_cap, rom_lim;
	logic [17:0] ram_phys, ram_size, ram_cap, ram_lim;
	logic        rom_formed;
	logic        ram_go;

	assign a = item.bus_addr;
	assign off = a[12:0];
	assign hi = state.ram_bank[1:0];
	assign mask1 = mbc1_mask(cfg.rom_bank_count);

	assign rom_size = {cfg.rom_bank_count, 14'd0};
	assign rom_cap  = 24'd1 << ROM_ADDR_BITS;
	assign rom_lim  = (rom_size < rom_cap) ? rom_size : rom_cap;
	assign ram_size = cfg.ram_is_2kib ? 18'd2048 : {cfg.ram_bank_count, 13'd0};
	assign ram_cap  = 18'd1 << RAM_ADDR_BITS;
	assign ram_lim  = (ram_size < ram_cap) ? ram_size : ram_cap;

	// MBC1 upper bank bits taken from the secondary bank register.
	always_comb begin
		if (cfg.rom_bank_count <= 10'd32)
			zb = 7'd0;
		else if (cfg.rom_bank_count == 10'd64)
			zb = {1'b0, hi[0], 5'd0};
		else
			zb = {hi, 5'd0};
		if (cfg.rom_bank_count > 10'd32)
			bank1 = {zb[6:5], state.rom_bank[4:0] & mask1};
		else
			bank1 = {2'd0, state.rom_bank[4:0] & mask1};
	end

	always_comb begin
		rom_phys = 24'd0;
		rom_formed = 1'b0;
		case (cfg.mapper_type)
			MAPPER_NONE: begin
				rom_phys = {8'd0, a};
				rom_formed = 1'b1;
			end
			MAPPER_MBC1: begin
				if (!a[14])
					rom_phys = state.banking_mode ? {3'd0, zb, a[13:0]} : {8'd0, a};
				else
					rom_phys = {3'd0, bank1, a[13:0]};
				rom_formed = 1'b1;
			end
			MAPPER_MBC5: begin
				rom_phys = !a[14] ? {8'd0, a} : {1'b0, state.rom_bank, a[13:0]};
				rom_formed = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ram_phys = 18'd0;
		if (cfg.mapper_type == MAPPER_MBC1) begin
			if (cfg.ram_bank_count == 5'd1)
				ram_phys = {5'd0, off & (cfg.ram_is_2kib ? 13'h07FF : 13'h1FFF)};
			else if (state.banking_mode)
				ram_phys = {3'd0, hi, off};
			else
				ram_phys = {5'd0, off};
		end else begin
			ram_phys = {1'b0, state.ram_bank, off};
		end
	end

	assign ram_go = state.ram_enabled
		&& (cfg.mapper_type == MAPPER_MBC1 || cfg.mapper_type == MAPPER_MBC5);

	always_comb begin
		result = '0;
		if (!item.req_type[1]) begin
			if (a[15]) begin
				result.out_of_range = 1'b1;
			end else if (item.req_type == REQ_ROM_RD && rom_formed) begin
				result.phys_addr = rom_phys[22:0];
				if (rom_phys >= rom_lim)
					result.out_of_range = 1'b1;
				else
					result.target = TGT_ROM;
			end
		end else begin
			if (a[15:13] != 3'b101) begin
				result.out_of_range = 1'b1;
			end else if (ram_go) begin
				result.phys_addr = {5'd0, ram_phys};
				if (ram_phys >= ram_lim) begin
					result.out_of_range = 1'b1;
				end else begin
					result.target = TGT_RAM;
					if (item.req_type == REQ_RAM_WR) begin
						result.write_strobe = 1'b1;
						result.write_byte = item.bus_data;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/cartridge_bank_mapper_unit.sv */
// Top level of the cartridge bank mapper: config registers and the two-register pipeline.
//
//  Channel  Direction  Handshake              Payload
//  in       to block   in_valid / in_stall    in_data (in_item_t)
//  out      from block out_valid / out_stall  out_data (out_item_t)
//  cfg      to block   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each access is captured in an input register and its result is registered in the
// output register; one transfer per cycle while out_stall stays low.
// Bank registers change when a ROM-area write passes from the input register
// to the output register, so the following access already sees the new banks.
// While out_stall holds, the input register keeps one more access, then in_stall rises.
// Reset clears the valid flags, sets the bank registers and the configuration to defaults.
`default_nettype none

module cartridge_bank_mapper_unit
	import cbm_pkg::*;
#(
	parameter int unsigned ROM_ADDR_BITS = 23,
	parameter int unsigned RAM_ADDR_BITS = 17
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_item_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_item_t                  out_data,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_regs_t   cfg_q;
	bank_state_t bank_state;
	in_item_t    item_s1;
	logic        valid_s1;
	out_item_t   result_s2;
	logic        valid_s2;
	out_item_t   result;
	logic        s2_free;
	logic        adv;
	logic        in_xfer;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mapper_type    <= MAPPER_NONE;
			cfg_q.rom_bank_count <= 10'd2;
			cfg_q.ram_bank_count <= 5'd0;
			cfg_q.ram_present    <= 1'b0;
			cfg_q.rumble_present <= 1'b0;
			cfg_q.ram_is_2kib    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAPPER_TYPE:    cfg_q.mapper_type    <= cfg_data[1:0];
				CFG_ROM_BANK_COUNT: cfg_q.rom_bank_count <= cfg_data[9:0];
				CFG_RAM_BANK_COUNT: cfg_q.ram_bank_count <= cfg_data[4:0];
				CFG_RAM_PRESENT:    cfg_q.ram_present    <= cfg_data[0];
				CFG_RUMBLE_PRESENT: cfg_q.rumble_present <= cfg_data[0];
				CFG_RAM_IS_2KIB:    cfg_q.ram_is_2kib    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign s2_free  = !valid_s2 || !out_stall;
	assign adv      = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_xfer)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (s2_free)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer)
			item_s1 <= in_data;
		if (adv)
			result_s2 <= result;
	end

	cbm_bank_regs u_bank_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (adv),
		.item   (item_s1),
		.cfg    (cfg_q),
		.state  (bank_state)
	);

	cbm_xlate #(
		.ROM_ADDR_BITS (ROM_ADDR_BITS),
		.RAM_ADDR_BITS (RAM_ADDR_BITS)
	) u_xlate (
		.item   (item_s1),
		.cfg    (cfg_q),
		.state  (bank_state),
		.result (result)
	);

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

endmodule

`default_nettype wire

/* tb/sv/cartridge_bank_mapper_checker.sv */
// Checker for the cartridge bank mapper: predicts each access and compares its result.
`timescale 1ns / 100ps

module cartridge_bank_mapper_checker
	import cbm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_stall,
	input  wire in_item_t              in_data,
	input  wire logic                  out_valid,
	input  wire logic                  out_stall,
	input  wire out_item_t             out_data,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         mismatches,
	output int                         outstanding,
	output int                         compared
);

	localparam int unsigned ROM_ADDR_BITS  = 23;
	localparam int unsigned RAM_ADDR_BITS  = 17;
	localparam int unsigned ROM_BANK_BYTES = 'h4000;
	localparam int unsigned RAM_BANK_BYTES = 'h2000;
	localparam int unsigned RAM_WIN_FIRST  = 'hA000;
	localparam int unsigned RAM_WIN_LAST   = 'hBFFF;
	localparam int unsigned ROM_AREA_LAST  = 'h7FFF;
	localparam int unsigned RAM_UNLOCK_KEY = 'hA;

	cfg_regs_t   card;
	bank_state_t banks;
	out_item_t   translations[$];
	out_item_t   want;
	int          mismatch_total;
	int          compared_total;

	function automatic int unsigned mbc1_bank_mask();
		int unsigned h;
		h = 32'(card.rom_bank_count);
		h = h >> 1;
		if (h > 16) h = 16;
		// With fewer than two banks h is zero and the mask opens to all five bits.
		return (h | (h - 1)) & 'h1F;
	endfunction

	function automatic int unsigned mbc5_bank_mask();
		int unsigned cnt;
		cnt = 32'(card.rom_bank_count);
		return (cnt - 1) & 'h1FF;
	endfunction

	function automatic int unsigned rom_bytes();
		int unsigned size;
		size = 32'(card.rom_bank_count);
		size = size * ROM_BANK_BYTES;
		return (size < (1 << ROM_ADDR_BITS)) ? size : (1 << ROM_ADDR_BITS);
	endfunction

	function automatic int unsigned ram_bytes();
		int unsigned size;
		size = 32'(card.ram_bank_count);
		size = card.ram_is_2kib ? 2048 : size * RAM_BANK_BYTES;
		return (size < (1 << RAM_ADDR_BITS)) ? size : (1 << RAM_ADDR_BITS);
	endfunction

	function automatic void load_bank_register(int unsigned a, int unsigned v);
		int unsigned rb;
		rb = 32'(banks.rom_bank);
		if (card.mapper_type == MAPPER_MBC1) begin
			if (a <= 'h1FFF) begin
				banks.ram_enabled = ((v & 'hF) == RAM_UNLOCK_KEY) && card.ram_present;
			end else if (a <= 'h3FFF) begin
				banks.rom_bank = 9'(((v & 'h1F) == 0) ? 1 : (v & mbc1_bank_mask()));
			end else if (a <= 'h5FFF) begin
				banks.ram_bank = 4'(v & 3);
			end else begin
				banks.banking_mode = v[0];
			end
		end else if (card.mapper_type == MAPPER_MBC5) begin
			if (a <= 'h1FFF) begin
				banks.ram_enabled = ((v & 'hF) == RAM_UNLOCK_KEY) && card.ram_present
					&& (card.ram_bank_count != 0);
			end else if (a <= 'h2FFF) begin
				banks.rom_bank = 9'(((rb & 'h100) | v) & mbc5_bank_mask());
			end else if (a <= 'h3FFF) begin
				banks.rom_bank = 9'(((rb & 'hFF) | ((v & 1) << 8)) & mbc5_bank_mask());
			end else if (a <= 'h5FFF) begin
				banks.ram_bank = 4'(v & (card.rumble_present ? 'h7 : 'hF));
			end
		end
	endfunction

	function automatic out_item_t translate_access(in_item_t acc);
		out_item_t   res;
		int unsigned a, v, phys, hi, zb, bank, cnt, rb, off;
		logic        formed;
		res = '0;
		a = 32'(acc.bus_addr);
		v = 32'(acc.bus_data);
		phys = 0;
		formed = 1'b0;
		cnt = 32'(card.rom_bank_count);
		rb = 32'(banks.ram_bank);
		if (acc.req_type == REQ_ROM_RD || acc.req_type == REQ_ROM_WR) begin
			if (a > ROM_AREA_LAST) begin
				res.out_of_range = 1'b1;
			end else if (acc.req_type == REQ_ROM_WR) begin
				load_bank_register(a, v);
			end else if (card.mapper_type == MAPPER_NONE) begin
				phys = a;
				formed = 1'b1;
			end else if (card.mapper_type == MAPPER_MBC1) begin
				// Large MBC1 carts borrow the RAM bank bits (only the low one at 64 banks) as upper ROM bank bits.
				hi = rb & 3;
				if (cnt <= 32) zb = 0;
				else if (cnt == 64) zb = (hi & 1) << 5;
				else zb = hi << 5;
				if (a < ROM_BANK_BYTES) begin
					phys = banks.banking_mode ? zb * ROM_BANK_BYTES + a : a;
				end else begin
					bank = 32'(banks.rom_bank) & mbc1_bank_mask();
					if (cnt > 32) bank = (bank & 'h1F) | zb;
					phys = bank * ROM_BANK_BYTES + (a - ROM_BANK_BYTES);
				end
				formed = 1'b1;
			end else if (card.mapper_type == MAPPER_MBC5) begin
				bank = 32'(banks.rom_bank);
				phys = (a < ROM_BANK_BYTES) ? a : bank * ROM_BANK_BYTES + (a - ROM_BANK_BYTES);
				formed = 1'b1;
			end
			if (formed) begin
				if (phys >= rom_bytes()) res.out_of_range = 1'b1;
				else res.target = TGT_ROM;
			end
		end else begin
			if (a < RAM_WIN_FIRST || a > RAM_WIN_LAST) begin
				res.out_of_range = 1'b1;
			end else if (banks.ram_enabled && (card.mapper_type == MAPPER_MBC1
					|| card.mapper_type == MAPPER_MBC5)) begin
				off = a - RAM_WIN_FIRST;
				if (card.mapper_type == MAPPER_MBC1) begin
					if (card.ram_bank_count == 1)
						phys = off & (card.ram_is_2kib ? 'h7FF : 'h1FFF);
					else
						phys = banks.banking_mode ? (rb & 3) * RAM_BANK_BYTES + off : off;
				end else begin
					phys = rb * RAM_BANK_BYTES + off;
				end
				if (phys >= ram_bytes()) begin
					res.out_of_range = 1'b1;
				end else begin
					res.target = TGT_RAM;
					if (acc.req_type == REQ_RAM_WR) begin
						res.write_strobe = 1'b1;
						res.write_byte = acc.bus_data;
					end
				end
			end
		end
		res.phys_addr = phys[22:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			card = {MAPPER_NONE, 10'd2, 5'd0, 1'b0, 1'b0, 1'b0};
			banks = {9'd1, 4'd0, 1'b0, 1'b0};
			translations.delete();
			mismatch_total = 0;
			compared_total = 0;
			mismatches <= 0;
			outstanding <= 0;
			compared <= 0;
		end else begin
			// Retire the oldest prediction first; a result can never belong to an
			// access accepted at the same edge.
			if (out_valid && !out_stall) begin
				if (translations.size() == 0) begin
					$error("result transfer with no access outstanding: %h", out_data);
					mismatch_total++;
				end else begin
					want = translations.pop_front();
					compared_total++;
					if (out_data.target !== want.target) begin
						$error("target: expected %0d, got %0d", want.target, out_data.target);
						mismatch_total++;
					end
					if (out_data.phys_addr !== want.phys_addr) begin
						$error("phys_addr: expected %h, got %h",
							want.phys_addr, out_data.phys_addr);
						mismatch_total++;
					end
					if (out_data.write_strobe !== want.write_strobe) begin
						$error("write_strobe: expected %0d, got %0d",
							want.write_strobe, out_data.write_strobe);
						mismatch_total++;
					end
					if (out_data.write_byte !== want.write_byte) begin
						$error("write_byte: expected %h, got %h",
							want.write_byte, out_data.write_byte);
						mismatch_total++;
					end
					if (out_data.out_of_range !== want.out_of_range) begin
						$error("out_of_range: expected %0d, got %0d",
							want.out_of_range, out_data.out_of_range);
						mismatch_total++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MAPPER_TYPE:    card.mapper_type = cfg_data[1:0];
					CFG_ROM_BANK_COUNT: card.rom_bank_count = cfg_data[9:0];
					CFG_RAM_BANK_COUNT: card.ram_bank_count = cfg_data[4:0];
					CFG_RAM_PRESENT:    card.ram_present = cfg_data[0];
					CFG_RUMBLE_PRESENT: card.rumble_present = cfg_data[0];
					CFG_RAM_IS_2KIB:    card.ram_is_2kib = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				translations.push_back(translate_access(in_data));
			mismatches <= mismatch_total;
			outstanding <= translations.size();
			compared <= compared_total;
		end
	end

endmodule

/* tb/sv/cartridge_bank_mapper_unit_test.sv */
// Testbench top for the cartridge bank mapper: stimulus, flow control and the verdict.
`timescale 1ns / 100ps

module cartridge_bank_mapper_unit_test;
	import cbm_pkg::*;

	localparam logic [1:0] MAPPER_UNUSED   = 2'd3;
	localparam int         RESET_CYCLES    = 11;
	localparam int         MAX_WAIT        = 10;
	localparam int         SETTLE_CYCLES   = 4;
	localparam int         IDLE_LIMIT      = 1000;
	localparam int         RANDOM_SETTINGS = 14;
	localparam int         RANDOM_PER_SET  = 43;
	localparam logic [3:0] RAM_UNLOCK_KEY  = 4'hA;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int mismatches;
	int outstanding;
	int compared;
	int idle_cycles = 0;
	int accesses_sent = 0;
	int settings_used = 0;
	int unsigned tx_max_gap = MAX_WAIT;
	int unsigned rx_max_stall = MAX_WAIT;
	int unsigned rx_wait;
	int unsigned stall_left = 0;
	int unsigned results_seen = 0;

	always #1 clk = ~clk;

	cartridge_bank_mapper_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cartridge_bank_mapper_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.compared    (compared)
	);

	// Result side: after each transfer hold stall for a random count. Every 40 results
	// the ceiling is redrawn, so some stretches run without any stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			results_seen <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= (stall_left > 1);
		end else if (out_valid && !out_stall) begin
			rx_wait = $urandom_range(0, rx_max_stall);
			stall_left <= rx_wait;
			out_stall <= (rx_wait != 0);
			results_seen <= results_seen + 1;
			if (results_seen % 40 == 39)
				rx_max_stall = ($urandom_range(0, 2) == 0) ? 0 : MAX_WAIT;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic cfg_regs_t card_setting(int unsigned k);
		case (k)
			0:  return {MAPPER_MBC1,   10'd32,   5'd4,  1'b1, 1'b0, 1'b0};
			1:  return {MAPPER_MBC1,   10'd128,  5'd4,  1'b1, 1'b0, 1'b0};
			2:  return {MAPPER_MBC1,   10'd512,  5'd1,  1'b1, 1'b0, 1'b1};
			3:  return {MAPPER_MBC1,   10'd0,    5'd1,  1'b1, 1'b0, 1'b0};
			4:  return {MAPPER_MBC1,   10'd72,   5'd3,  1'b1, 1'b0, 1'b0};
			5:  return {MAPPER_MBC5,   10'd512,  5'd16, 1'b1, 1'b0, 1'b0};
			6:  return {MAPPER_MBC5,   10'd2,    5'd16, 1'b1, 1'b1, 1'b0};
			7:  return {MAPPER_MBC5,   10'd0,    5'd0,  1'b1, 1'b0, 1'b0};
			8:  return {MAPPER_MBC5,   10'd96,   5'd31, 1'b1, 1'b0, 1'b0};
			9:  return {MAPPER_MBC5,   10'd1023, 5'd8,  1'b0, 1'b0, 1'b0};
			10: return {MAPPER_UNUSED, 10'd16,   5'd4,  1'b1, 1'b0, 1'b0};
			11: return {MAPPER_NONE,   10'd4,    5'd2,  1'b1, 1'b0, 1'b0};
			12: return {MAPPER_MBC1,   10'd2,    5'd0,  1'b1, 1'b0, 1'b1};
			default: return {MAPPER_MBC1, 10'd1, 5'd31, 1'b1, 1'b1, 1'b1};
		endcase
	endfunction

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_card(input cfg_regs_t s);
		write_register(CFG_MAPPER_TYPE, CFG_DATA_W'(s.mapper_type));
		write_register(CFG_ROM_BANK_COUNT, s.rom_bank_count);
		write_register(CFG_RAM_BANK_COUNT, CFG_DATA_W'(s.ram_bank_count));
		write_register(CFG_RAM_PRESENT, CFG_DATA_W'(s.ram_present));
		write_register(CFG_RUMBLE_PRESENT, CFG_DATA_W'(s.rumble_present));
		write_register(CFG_RAM_IS_2KIB, CFG_DATA_W'(s.ram_is_2kib));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Holds off new accesses until every outstanding result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_access(input logic [1:0] req, input logic [15:0] addr,
			input logic [7:0] data);
		int unsigned gap;
		gap = $urandom_range(0, tx_max_gap);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= {req, addr, data};
		do @(posedge clk); while (in_stall);
		accesses_sent++;
	endtask

	task automatic send_random_access();
		int unsigned pick;
		logic [1:0]  req;
		logic [15:0] addr;
		logic [7:0]  data;
		pick = $urandom_range(0, 99);
		data = 8'($urandom_range(0, 255));
		if (pick < 8) begin
			req = 2'($urandom_range(0, 3));
			addr = 16'($urandom_range(0, 16'hFFFF));
		end else if (pick < 30) begin
			req = REQ_ROM_WR;
			addr = 16'($urandom_range(0, 16'h7FFF));
			// Bias writes to the enable range toward the unlock value so RAM stays reachable.
			if (addr <= 16'h1FFF && $urandom_range(0, 3) != 0)
				data[3:0] = RAM_UNLOCK_KEY;
		end else if (pick < 60) begin
			req = REQ_ROM_RD;
			addr = 16'($urandom_range(0, 16'h7FFF));
		end else begin
			req = ($urandom_range(0, 1) != 0) ? REQ_RAM_WR : REQ_RAM_RD;
			addr = 16'($urandom_range(16'hA000, 16'hBFFF));
		end
		send_access(req, addr, data);
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Plain ROM cart: area edges, out-of-area addresses and open-bus RAM.
		program_card({MAPPER_NONE, 10'd2, 5'd0, 1'b0, 1'b0, 1'b0});
		send_access(REQ_ROM_RD, 16'h0000, 8'h00);
		send_access(REQ_ROM_RD, 16'h7FFF, 8'hFF);
		send_access(REQ_ROM_RD, 16'h8000, 8'h00);
		send_access(REQ_ROM_WR, 16'hFFFF, 8'hFF);
		send_access(REQ_ROM_WR, 16'h0000, 8'h0A);
		send_access(REQ_RAM_RD, 16'hA000, 8'h00);
		send_access(REQ_RAM_WR, 16'hBFFF, 8'hFF);
		send_access(REQ_RAM_RD, 16'h9FFF, 8'h00);
		send_access(REQ_RAM_WR, 16'hC000, 8'h5A);
		drain_results();

		// MBC1 with 64 banks: bank zero remap, upper bank bits, mode 1 and RAM lock.
		program_card({MAPPER_MBC1, 10'd64, 5'd4, 1'b1, 1'b0, 1'b0});
		send_access(REQ_ROM_WR, 16'h0000, 8'h0A);
		send_access(REQ_ROM_WR, 16'h2000, 8'h00);
		send_access(REQ_ROM_RD, 16'h4000, 8'h00);
		send_access(REQ_ROM_WR, 16'h3FFF, 8'hFF);
		send_access(REQ_ROM_WR, 16'h4000, 8'h03);
		send_access(REQ_ROM_WR, 16'h6000, 8'h01);
		send_access(REQ_ROM_RD, 16'h0000, 8'h00);
		send_access(REQ_ROM_RD, 16'h7FFF, 8'h00);
		send_access(REQ_RAM_WR, 16'hA000, 8'hFF);
		send_access(REQ_RAM_RD, 16'hBFFF, 8'h00);
		send_access(REQ_ROM_WR, 16'h1FFF, 8'h00);
		send_access(REQ_RAM_RD, 16'hA123, 8'h00);

		for (int unsigned k = 0; k < RANDOM_SETTINGS; k++) begin
			drain_results();
			tx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : MAX_WAIT;
			program_card(card_setting(k));
			send_access(REQ_ROM_WR, 16'h0000, {4'h0, RAM_UNLOCK_KEY});
			repeat (RANDOM_PER_SET) send_random_access();
		end
		drain_results();

		$display("Run covered %0d bus accesses under %0d cartridge settings, %0d results compared.",
			accesses_sent, settings_used, compared);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
